FILE: rtl/mst_pkg.sv
// ----------------------------------------------------------------------------
// mst_pkg: shared types and codes of the multichannel soft timer
// Holds the action codes and the request and response transaction structs.
// ----------------------------------------------------------------------------
`default_nettype none

package mst_pkg;

  localparam logic [2:0] ActAdvance  = 3'd0;
  localparam logic [2:0] ActRegister = 3'd1;
  localparam logic [2:0] ActRestart  = 3'd2;
  localparam logic [2:0] ActQuery    = 3'd3;
  localparam logic [2:0] ActInit     = 3'd4;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  channel;
    logic [63:0] amount;
  } mst_req_t;

  typedef struct packed {
    logic        ok;
    logic        arrived;
    logic [63:0] now_ms;
  } mst_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/multichannel_soft_timer.sv
// ----------------------------------------------------------------------------
// multichannel_soft_timer: 64-bit millisecond clock with a bank of timers
// Command-driven timer bank; an advance scans all channels for deadlines.
// ----------------------------------------------------------------------------
// A transaction is accepted when start_i is high and busy_o is low. Every
// transaction yields exactly one response, shown on rsp_o for one cycle with
// valid_o high; the receiver cannot stall, so capture it in that cycle.
// Register, restart, query and init finish in the accept cycle: the response
// follows on the next cycle and busy_o stays low, so these may be issued
// back to back. An advance holds busy_o high through the deadline scan that
// follows its acceptance, and its response comes with the cycle in which
// busy_o drops. The scan is paced by its structure: the start and duration
// stores have one read port, so one channel is read per cycle, and one shared
// 64-bit adder forms start + duration, followed by a compare stage against
// the clock. The shared adder also performs the clock advance itself in the
// accept cycle. All sums wrap modulo 2^64. Register, restart and query with a
// channel at or above NUM_CHANNELS answer ok = 0 and leave the state alone.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_soft_timer #(
  parameter int NUM_CHANNELS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire mst_pkg::mst_req_t  req_i,
  output logic                    busy_o,
  output logic                    valid_o,
  output mst_pkg::mst_rsp_t       rsp_o
);

  localparam int IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CW = $clog2(NUM_CHANNELS + 1);
  localparam logic [8:0] NumChW = 9'(NUM_CHANNELS);

  // Sequencer states
  localparam logic StIdle = 1'b0;
  localparam logic StScan = 1'b1;

  logic state_q, state_d;

  // Architectural state
  logic [63:0]             clock_q, clock_d;
  logic [NUM_CHANNELS-1:0] reg_mark_q, reg_mark_d;
  logic [NUM_CHANNELS-1:0] arr_mark_q, arr_mark_d;

  // Channel stores, one read port, read data registered
  logic [63:0] start_mem [NUM_CHANNELS];
  logic [63:0] dur_mem   [NUM_CHANNELS];
  logic [63:0] start_rd_q, dur_rd_q;
  logic [IW-1:0] rd_addr;
  logic          wr_start, wr_dur;

  // Scan pipeline: issue counter, read stage, sum stage
  logic [CW-1:0] issue_q, issue_d;
  logic          v1_q, v1_d, v2_q, v2_d;
  logic [IW-1:0] idx1_q, idx1_d, idx2_q, idx2_d;
  logic [63:0]   sum_q;
  logic          issue_done;

  // Shared adder
  logic [63:0] add_a, add_b, add_y;

  // Response register
  logic               valid_q, valid_d;
  mst_pkg::mst_rsp_t  rsp_q, rsp_d;

  // Request decode
  logic          accept;
  logic          in_range;
  logic [IW-1:0] req_idx;

  assign accept     = start_i && !busy_o;
  assign in_range   = {1'b0, req_i.channel} < NumChW;
  assign req_idx    = req_i.channel[IW-1:0];
  assign issue_done = (issue_q == CW'(NUM_CHANNELS));

  // Feed the adder with the clock advance while idle and with the
  // channel deadline operands during the scan.
  always_comb begin
    if (state_q == StIdle) begin
      add_a = clock_q;
      add_b = req_i.amount;
    end else begin
      add_a = start_rd_q;
      add_b = dur_rd_q;
    end
  end
  assign add_y = add_a + add_b;

  always_comb begin
    state_d    = state_q;
    clock_d    = clock_q;
    reg_mark_d = reg_mark_q;
    arr_mark_d = arr_mark_q;
    issue_d    = issue_q;
    v1_d       = 1'b0;
    v2_d       = v1_q;
    idx1_d     = idx1_q;
    idx2_d     = idx1_q;
    valid_d    = 1'b0;
    rsp_d      = rsp_q;
    wr_start   = 1'b0;
    wr_dur     = 1'b0;
    rd_addr    = issue_q[IW-1:0];

    case (state_q)
      StIdle: begin
        if (accept) begin
          rsp_d.ok      = 1'b0;
          rsp_d.arrived = 1'b0;
          case (req_i.action)
            mst_pkg::ActAdvance: begin
              // Advance the clock now, then sweep the channels
              clock_d = add_y;
              issue_d = '0;
              state_d = StScan;
            end
            mst_pkg::ActRegister: begin
              valid_d = 1'b1;
              if (in_range && !reg_mark_q[req_idx]) begin
                wr_start            = 1'b1;
                wr_dur              = 1'b1;
                reg_mark_d[req_idx] = 1'b1;
                arr_mark_d[req_idx] = 1'b0;
                rsp_d.ok            = 1'b1;
              end
            end
            mst_pkg::ActRestart: begin
              valid_d = 1'b1;
              if (in_range && reg_mark_q[req_idx]) begin
                wr_start            = 1'b1;
                arr_mark_d[req_idx] = 1'b0;
                rsp_d.ok            = 1'b1;
              end
            end
            mst_pkg::ActQuery: begin
              valid_d = 1'b1;
              if (in_range && reg_mark_q[req_idx] && arr_mark_q[req_idx]) begin
                rsp_d.ok      = 1'b1;
                rsp_d.arrived = 1'b1;
              end
            end
            mst_pkg::ActInit: begin
              valid_d    = 1'b1;
              clock_d    = req_i.amount;
              reg_mark_d = '0;
              arr_mark_d = '0;
              rsp_d.ok   = 1'b1;
            end
            default: begin
              // Unused codes: answer ok = 0 and drop the transaction
              valid_d = 1'b1;
            end
          endcase
          rsp_d.now_ms = clock_d;
        end
      end
      StScan: begin
        // Issue one channel read per cycle
        if (!issue_done) begin
          v1_d    = 1'b1;
          idx1_d  = issue_q[IW-1:0];
          issue_d = issue_q + CW'(1);
        end
        // Compare the registered deadline against the advanced clock
        if (v2_q && reg_mark_q[idx2_q] && !arr_mark_q[idx2_q] &&
            (clock_q >= sum_q)) begin
          arr_mark_d[idx2_q] = 1'b1;
        end
        if (issue_done && !v1_q && !v2_q) begin
          state_d       = StIdle;
          valid_d       = 1'b1;
          rsp_d.ok      = 1'b1;
          rsp_d.arrived = 1'b0;
          rsp_d.now_ms  = clock_q;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      clock_q    <= '0;
      reg_mark_q <= '0;
      arr_mark_q <= '0;
      issue_q    <= '0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      clock_q    <= clock_d;
      reg_mark_q <= reg_mark_d;
      arr_mark_q <= arr_mark_d;
      issue_q    <= issue_d;
      v1_q       <= v1_d;
      v2_q       <= v2_d;
      valid_q    <= valid_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    idx1_q <= idx1_d;
    idx2_q <= idx2_d;
    sum_q  <= add_y;
    rsp_q  <= rsp_d;
  end

  // Channel stores
  always_ff @(posedge clk_i) begin
    if (wr_start) begin
      start_mem[req_idx] <= clock_q;
    end
    if (wr_dur) begin
      dur_mem[req_idx] <= req_i.amount;
    end
    start_rd_q <= start_mem[rd_addr];
    dur_rd_q   <= dur_mem[rd_addr];
  end

  assign busy_o  = (state_q != StIdle);
  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

`ifndef SYNTHESIS
  // An accepted advance holds the block busy with no response next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.action == mst_pkg::ActAdvance) |=> (busy_o && !valid_o))
    else $error("advance did not enter the scan");

  // Any other accepted transaction responds on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.action != mst_pkg::ActAdvance) |=> (valid_o && !busy_o))
    else $error("single-cycle action did not respond");

  // Scan pipeline stages only run while scanning
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q || v2_q) |-> (state_q == StScan))
    else $error("scan stage active outside the scan");

  // An arrived mark never sets on an unregistered channel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((arr_mark_q & ~reg_mark_q) == '0) |=> ((arr_mark_q & ~reg_mark_q) == '0))
    else $error("arrived mark on unregistered channel");
`endif

endmodule

`default_nettype wire
